FILE: src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: src/lzwe_pkg.sv
package lzwe_pkg;

    localparam int DICT_SIZE_DEF = 4096;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = 2;

    localparam logic [11:0] FIRST_CODE   = 12'd256;
    localparam logic [11:0] TOP_CODE     = 12'd4095;
    localparam logic [11:0] MAX_CODE_RST = 12'd4095;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } lzwe_in_t;

    typedef struct packed {
        logic [11:0] code;
        logic        last;
    } lzwe_out_t;

    // queue head as seen by the engine
    typedef struct packed {
        logic     valid;
        lzwe_in_t item;
    } lzwe_head_t;

    typedef struct packed {
        logic [11:0] next_code;
        logic        full;
        logic        busy;
    } lzwe_status_t;

endpackage

FILE: src/lzwe_front.sv
module lzwe_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lzwe_pkg::lzwe_in_t  s_item,
    output lzwe_pkg::lzwe_head_t head,
    input  logic                pop
);
    import lzwe_pkg::*;

    lzwe_in_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                push, do_pop;

    assign s_ready = (count_reg != QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

FILE: src/lzwe_engine.sv
module lzwe_engine #(
    parameter int DICT_SIZE = lzwe_pkg::DICT_SIZE_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [11:0]            max_code,
    input  lzwe_pkg::lzwe_head_t   head,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lzwe_pkg::lzwe_out_t    m_item,
    output lzwe_pkg::lzwe_status_t status
);
    import lzwe_pkg::*;

    localparam int HW     = $clog2(DICT_SIZE);
    localparam int CODES  = (DICT_SIZE < 4096) ? DICT_SIZE : 4096;
    localparam int DDEPTH = CODES - 256;
    localparam int DW     = $clog2(DDEPTH);
    localparam logic [11:0] CODE_LIMIT = 12'(CODES - 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_HREAD  = 6'b000010,
        ST_DREAD  = 6'b000100,
        ST_CMP    = 6'b001000,
        ST_MISS   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    // hash slot: code in 31..20, key in 19..0
    logic [31:0]   hash_mem [DICT_SIZE];
    logic [19:0]   dict_mem [DDEPTH];
    logic [31:0]   hash_rdata;
    logic [19:0]   dict_rdata;

    state_t        state_reg, state_next;
    logic [11:0]   next_code_reg, next_code_next;
    logic          full_reg, full_next;
    logic [11:0]   prefix_reg, prefix_next;
    logic          have_reg, have_next;
    logic [7:0]    byte_reg, byte_next;
    logic          eom_reg, eom_next;
    logic [HW-1:0] haddr_reg, haddr_next;
    logic [HW-1:0] probe_reg, probe_next;
    logic          m_valid_reg, m_valid_next;
    lzwe_out_t     m_item_reg, m_item_next;

    logic [19:0]   key;
    logic [19:0]   new_key;
    logic [11:0]   slot_code;
    logic [19:0]   slot_key;
    logic          slot_live;
    logic          out_free;
    logic          grow;
    logic          hash_we, dict_we, dict_re;

    assign key       = {prefix_reg, byte_reg};
    assign new_key   = {prefix_reg, head.item.data_byte};
    assign slot_code = hash_rdata[31:20];
    assign slot_key  = hash_rdata[19:0];
    // code handed out in this message: dictionary entry behind it was written
    assign slot_live = (slot_code >= FIRST_CODE) && (full_reg || slot_code < next_code_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign grow      = !full_reg && (next_code_reg <= max_code) && (next_code_reg <= CODE_LIMIT);

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign status.next_code = next_code_reg;
    assign status.full      = full_reg;
    assign status.busy      = (state_reg != ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        next_code_next = next_code_reg;
        full_next      = full_reg;
        prefix_next    = prefix_reg;
        have_next      = have_reg;
        byte_next      = byte_reg;
        eom_next       = eom_reg;
        haddr_next     = haddr_reg;
        probe_next     = probe_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_item_next    = m_item_reg;
        pop            = 1'b0;
        hash_we        = 1'b0;
        dict_we        = 1'b0;
        dict_re        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    pop       = 1'b1;
                    byte_next = head.item.data_byte;
                    eom_next  = head.item.end_of_message;
                    if (!have_reg) begin
                        prefix_next = {4'd0, head.item.data_byte};
                        have_next   = 1'b1;
                        state_next  = ST_FINISH;
                    end else begin
                        haddr_next = new_key[HW-1:0] ^ HW'(new_key >> HW);
                        probe_next = '0;
                        state_next = ST_HREAD;
                    end
                end
            end
            ST_HREAD: begin
                state_next = ST_DREAD;
            end
            ST_DREAD: begin
                if (slot_live) begin
                    dict_re    = 1'b1;
                    state_next = ST_CMP;
                end else begin
                    state_next = ST_MISS;
                end
            end
            ST_CMP: begin
                if (dict_rdata == key) begin
                    prefix_next = slot_code;
                    state_next  = ST_FINISH;
                end else if (dict_rdata == slot_key && probe_reg != '1) begin
                    // slot taken by another pair: linear probe
                    haddr_next = haddr_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    state_next = ST_HREAD;
                end else begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_item_next.code = prefix_reg;
                    m_item_next.last = 1'b0;
                    if (grow) begin
                        hash_we = 1'b1;
                        dict_we = 1'b1;
                        if (next_code_reg >= TOP_CODE) begin
                            full_next = 1'b1;
                        end else begin
                            next_code_next = next_code_reg + 1'b1;
                        end
                    end
                    prefix_next = {4'd0, byte_reg};
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!eom_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_item_next.code = prefix_reg;
                    m_item_next.last = 1'b1;
                    next_code_next   = FIRST_CODE;
                    full_next        = 1'b0;
                    prefix_next      = '0;
                    have_next        = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            next_code_reg <= FIRST_CODE;
            full_reg      <= 1'b0;
            prefix_reg    <= '0;
            have_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_code_reg <= next_code_next;
            full_reg      <= full_next;
            prefix_reg    <= prefix_next;
            have_reg      <= have_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        eom_reg    <= eom_next;
        haddr_reg  <= haddr_next;
        probe_reg  <= probe_next;
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (hash_we) begin
            hash_mem[haddr_reg] <= {next_code_reg, key};
        end
        if (state_reg == ST_HREAD) begin
            hash_rdata <= hash_mem[haddr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (dict_we) begin
            dict_mem[DW'(next_code_reg - FIRST_CODE)] <= key;
        end
        if (dict_re) begin
            dict_rdata <= dict_mem[DW'(slot_code - FIRST_CODE)];
        end
    end

endmodule

FILE: src/lzw_encoder.sv
// channel   dir   payload                         handshake
// s_        in    data_byte[7:0], end_of_message  s_valid / s_ready
// m_        out   code[11:0], last                m_valid / m_ready
// cfg_      in    max_code[11:0]                  cfg_valid / cfg_ready
//
// A byte that starts a message goes straight to the finish state; any other
// byte is looked up in the hash table, each probe being one hash RAM read,
// then a dictionary RAM read and a compare if the slot is live. A miss emits
// its code from the miss state; the final code of a message from the finish state.
// Reset is synchronous, active low; no RAM clearing is needed.
// A 4-deep input queue keeps s_ready up while the engine waits on m_ready, until it fills.
module lzw_encoder #(
    parameter int DICT_SIZE = lzwe_pkg::DICT_SIZE_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lzwe_pkg::lzwe_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output lzwe_pkg::lzwe_out_t m_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [11:0]         cfg_data
);
    import lzwe_pkg::*;

    `include "assert_macros.svh"

    logic [11:0]  max_code_reg;
    lzwe_head_t   head;
    logic         pop;
    lzwe_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_code_reg <= MAX_CODE_RST;
        end else if (cfg_valid && cfg_ready) begin
            max_code_reg <= cfg_data;
        end
    end

    lzwe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .head    (head),
        .pop     (pop)
    );

    lzwe_engine #(
        .DICT_SIZE (DICT_SIZE)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .max_code (max_code_reg),
        .head     (head),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .status   (status)
    );

    `ASSERT_CLK(a_code_range, aclk, aresetn, status.next_code >= FIRST_CODE)
    `ASSERT_CLK(a_full_top, aclk, aresetn, status.full |-> status.next_code == TOP_CODE)
    `ASSERT_NEVER(a_pop_empty, aclk, aresetn, pop && !head.valid)
    `ASSERT_CLK(a_stall_full, aclk, aresetn, !s_ready |-> head.valid)
    `ASSERT_NEVER(a_cfg_idle, aclk, aresetn, cfg_valid && status.busy)

endmodule
